// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the filter kernel accumulator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check of a property, sampled on the rising clock edge.
`define FWA_ASSERT(name, clk, rstn, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Condition in one cycle implies a condition in the next cycle.
`define FWA_ASSERT_NEXT(name, clk, rstn, cond, nxt, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (nxt)) else $error(msg);

`endif

// ===== hdl/fwa_pkg.sv =====
// Shared types, constants and exp table functions for the kernel accumulator.
package fwa_pkg;

    localparam int EXP_TABLE_ENTRIES_DEF = 256;
    localparam int EXP_W = 25;
    localparam logic [EXP_W-1:0] ONE_Q24 = 25'h100_0000;

    localparam int NUM_REGS = 6;
    localparam int ADDR_W   = 5;

    localparam logic [2:0] REG_FILTER_MODE = 3'd0;
    localparam logic [2:0] REG_THREE_DIM   = 3'd1;
    localparam logic [2:0] REG_FILTER_W    = 3'd2;
    localparam logic [2:0] REG_INV_W       = 3'd3;
    localparam logic [2:0] REG_NORM        = 3'd4;
    localparam logic [2:0] REG_GAUSS_SCALE = 3'd5;

    localparam logic [1:0] MODE_BOX   = 2'd0;
    localparam logic [1:0] MODE_HAT   = 2'd1;
    localparam logic [1:0] MODE_GAUSS = 2'd2;
    localparam logic [1:0] MODE_QUAD  = 2'd3;

    localparam logic [1:0]  RST_FILTER_MODE = MODE_BOX;
    localparam logic        RST_THREE_DIM   = 1'b1;
    localparam logic [31:0] RST_FILTER_W    = 32'd1048576;
    localparam logic [31:0] RST_INV_W       = 32'd16777216;
    localparam logic [31:0] RST_NORM        = 32'd16777216;
    localparam logic [31:0] RST_GAUSS_SCALE = 32'd8388608;

    localparam logic [33:0] DIV3_RECIP = 34'h0_AAAA_AAAB;

    typedef struct packed {
        logic [1:0]  filter_mode;
        logic        three_dim;
        logic [31:0] filter_width;
        logic [31:0] inv_filter_width;
        logic [31:0] norm_factor;
        logic [31:0] gauss_exp_scale;
    } cfg_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_OM_A,
        OP_SQ_T,
        OP_OM_3A,
        OP_SQ_S,
        OP_DIV3,
        OP_QSUB,
        OP_SH_ONE,
        OP_SH_ZERO,
        OP_SH_T,
        OP_SH_Q,
        OP_SH_MT,
        OP_SH_MQ,
        OP_SQ_A,
        OP_R2_ADD,
        OP_KH,
        OP_KL,
        OP_K,
        OP_POS,
        OP_TAB,
        OP_STEP,
        OP_INTERP,
        OP_W,
        OP_WV,
        OP_C1,
        OP_C2,
        OP_CSUM,
        OP_ACC
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [1:0] axis;
    } cmd_t;

    typedef struct packed {
        logic inside_le;
        logic inside_lt;
        logic small3;
        logic gauss_far;
        logic k_far;
        logic last;
        logic out_busy;
    } status_t;

    // exp(-f) in Q.32 for f < 1.0, truncated Taylor series
    function automatic logic [63:0] exp_frac_q32(input logic [63:0] f);
        logic signed [63:0] sum;
        logic [63:0] term;
        sum  = 64'sh1_0000_0000;
        term = 64'h1_0000_0000;
        for (int k = 1; k <= 24; k++) begin
            term = ((term * f) >> 32) / 64'(k);
            if (k % 2 == 1)
                sum = sum - $signed(term);
            else
                sum = sum + $signed(term);
        end
        return (sum > 0) ? 64'(sum) : 64'd0;
    endfunction

    // Table entry exp(-y) in Q1.24 for y in Q.32
    function automatic logic [EXP_W-1:0] exp_table_value(input logic [63:0] y);
        logic [63:0] e1;
        logic [63:0] r;
        logic [63:0] n;
        e1 = exp_frac_q32(64'h8000_0000);
        e1 = (e1 * e1) >> 32;
        n  = y >> 32;
        r  = exp_frac_q32(y & 64'hFFFF_FFFF);
        for (int j = 0; j < 16; j++) begin
            if (64'(j) < n)
                r = (r * e1) >> 32;
        end
        r = (r + 64'd128) >> 8;
        return r[EXP_W-1:0];
    endfunction

endpackage

// ===== hdl/filter_kernel_weighted_accumulate.sv =====
// Top level of the kernel-weighted neighbor accumulator.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------------------
//  cfg     | in        | psel/penable/pready| paddr, pwdata, prdata (6 registers)
//  s_      | in        | s_valid/s_ready    | cell xyz, query xyz, volume, value, last
//  m_      | out       | m_valid/m_ready    | weighted_sum, weight_volume_sum, saturated
//
// One item at a time through a shared 34x34 multiplier sequenced by the controller.
// An item's duration depends on the mode, from box (shortest) up to 3-D quadratic
// (longest); hat and Gaussian lie between. The operands are loaded as the item is accepted.
// Reset (aresetn low, synchronous) clears the sums, the saturation flag and the result valid.
// The result register holds a finished sum while the next query is taken; only the
// final accumulate of the next last item waits until it is read.
module filter_kernel_weighted_accumulate
    import fwa_pkg::*;
#(
    parameter int EXP_TABLE_ENTRIES = EXP_TABLE_ENTRIES_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_cell_x,
    input  logic signed [31:0] s_cell_y,
    input  logic signed [31:0] s_cell_z,
    input  logic signed [31:0] s_query_x,
    input  logic signed [31:0] s_query_y,
    input  logic signed [31:0] s_query_z,
    input  logic [31:0]        s_cell_volume,
    input  logic signed [31:0] s_field_value,
    input  logic               s_last_item,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [63:0] m_weighted_sum,
    output logic signed [63:0] m_weight_volume_sum,
    output logic               m_saturated
);

    cfg_t    cfg;
    cmd_t    cmd;
    status_t status;

    fwa_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    fwa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    fwa_dp #(
        .EXP_TABLE_ENTRIES (EXP_TABLE_ENTRIES)
    ) u_dp (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg                 (cfg),
        .cmd                 (cmd),
        .status              (status),
        .s_cell_x            (s_cell_x),
        .s_cell_y            (s_cell_y),
        .s_cell_z            (s_cell_z),
        .s_query_x           (s_query_x),
        .s_query_y           (s_query_y),
        .s_query_z           (s_query_z),
        .s_cell_volume       (s_cell_volume),
        .s_field_value       (s_field_value),
        .s_last_item         (s_last_item),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_weighted_sum      (m_weighted_sum),
        .m_weight_volume_sum (m_weight_volume_sum),
        .m_saturated         (m_saturated)
    );

endmodule

// ===== hdl/fwa_regs.sv =====
// APB configuration register block.
module fwa_regs
    import fwa_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t       cfg_reg;
    logic [2:0] reg_idx;
    logic       wr_en;

    assign reg_idx = paddr[4:2];
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign cfg     = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.filter_mode      <= RST_FILTER_MODE;
            cfg_reg.three_dim        <= RST_THREE_DIM;
            cfg_reg.filter_width     <= RST_FILTER_W;
            cfg_reg.inv_filter_width <= RST_INV_W;
            cfg_reg.norm_factor      <= RST_NORM;
            cfg_reg.gauss_exp_scale  <= RST_GAUSS_SCALE;
        end else if (wr_en) begin
            case (reg_idx)
                REG_FILTER_MODE: cfg_reg.filter_mode      <= pwdata[1:0];
                REG_THREE_DIM:   cfg_reg.three_dim        <= pwdata[0];
                REG_FILTER_W:    cfg_reg.filter_width     <= pwdata;
                REG_INV_W:       cfg_reg.inv_filter_width <= pwdata;
                REG_NORM:        cfg_reg.norm_factor      <= pwdata;
                REG_GAUSS_SCALE: cfg_reg.gauss_exp_scale  <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_FILTER_MODE: prdata = {30'd0, cfg_reg.filter_mode};
            REG_THREE_DIM:   prdata = {31'd0, cfg_reg.three_dim};
            REG_FILTER_W:    prdata = cfg_reg.filter_width;
            REG_INV_W:       prdata = cfg_reg.inv_filter_width;
            REG_NORM:        prdata = cfg_reg.norm_factor;
            REG_GAUSS_SCALE: prdata = cfg_reg.gauss_exp_scale;
            default:         prdata = 32'd0;
        endcase
    end

endmodule

// ===== hdl/fwa_ctrl.sv =====
// Sequencer that steps one item through the shared multiplier datapath.
`include "assert_macros.svh"
module fwa_ctrl
    import fwa_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  cfg_t    cfg,
    input  logic    s_valid,
    output logic    s_ready,
    input  status_t status,
    output cmd_t    cmd
);

    typedef enum logic [23:0] {
        ST_IDLE   = 24'h000001,
        ST_SEL    = 24'h000002,
        ST_OM     = 24'h000004,
        ST_SQT    = 24'h000008,
        ST_OM3    = 24'h000010,
        ST_SQS    = 24'h000020,
        ST_DIV3   = 24'h000040,
        ST_QSUB   = 24'h000080,
        ST_SHP    = 24'h000100,
        ST_SQA    = 24'h000200,
        ST_R2     = 24'h000400,
        ST_KH     = 24'h000800,
        ST_KL     = 24'h001000,
        ST_K      = 24'h002000,
        ST_POS    = 24'h004000,
        ST_TAB    = 24'h008000,
        ST_STEP   = 24'h010000,
        ST_INTERP = 24'h020000,
        ST_W      = 24'h040000,
        ST_WV     = 24'h080000,
        ST_C1     = 24'h100000,
        ST_C2     = 24'h200000,
        ST_CSUM   = 24'h400000,
        ST_ACC    = 24'h800000
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] axis_reg, axis_next;
    logic [1:0] last_axis;
    logic       is_hat;

    assign last_axis = cfg.three_dim ? 2'd2 : 2'd1;
    assign is_hat    = (cfg.filter_mode == MODE_HAT);
    assign s_ready   = (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            axis_reg  <= 2'd0;
        end else begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        axis_next  = axis_reg;
        cmd.op     = OP_NONE;
        cmd.axis   = axis_reg;
        case (state_reg)
            ST_IDLE: begin
                axis_next = 2'd0;
                if (s_valid) begin
                    cmd.op     = OP_LOAD;
                    state_next = ST_SEL;
                end
            end
            ST_SEL: begin
                case (cfg.filter_mode)
                    MODE_BOX: begin
                        cmd.op     = status.inside_le ? OP_SH_ONE : OP_SH_ZERO;
                        state_next = ST_W;
                    end
                    MODE_HAT: begin
                        if (status.inside_le) begin
                            state_next = ST_OM;
                        end else begin
                            cmd.op     = OP_SH_ZERO;
                            state_next = ST_W;
                        end
                    end
                    MODE_GAUSS: state_next = ST_SQA;
                    default: begin
                        if (status.inside_lt) begin
                            state_next = ST_OM;
                        end else begin
                            cmd.op     = OP_SH_ZERO;
                            state_next = ST_W;
                        end
                    end
                endcase
            end
            ST_OM: begin
                cmd.op     = OP_OM_A;
                state_next = is_hat ? ST_SHP : ST_SQT;
            end
            ST_SQT: begin
                cmd.op     = OP_SQ_T;
                state_next = status.small3 ? ST_OM3 : ST_SHP;
            end
            ST_OM3: begin
                cmd.op     = OP_OM_3A;
                state_next = ST_SQS;
            end
            ST_SQS: begin
                cmd.op     = OP_SQ_S;
                state_next = ST_DIV3;
            end
            ST_DIV3: begin
                cmd.op     = OP_DIV3;
                state_next = ST_QSUB;
            end
            ST_QSUB: begin
                cmd.op     = OP_QSUB;
                state_next = ST_SHP;
            end
            ST_SHP: begin
                if (axis_reg == 2'd0)
                    cmd.op = is_hat ? OP_SH_T : OP_SH_Q;
                else
                    cmd.op = is_hat ? OP_SH_MT : OP_SH_MQ;
                if (axis_reg == last_axis) begin
                    state_next = ST_W;
                end else begin
                    axis_next  = axis_reg + 2'd1;
                    state_next = ST_OM;
                end
            end
            ST_SQA: begin
                cmd.op     = OP_SQ_A;
                state_next = ST_R2;
            end
            ST_R2: begin
                cmd.op = OP_R2_ADD;
                if (axis_reg == last_axis) begin
                    state_next = ST_KH;
                end else begin
                    axis_next  = axis_reg + 2'd1;
                    state_next = ST_SQA;
                end
            end
            ST_KH: begin
                cmd.op     = OP_KH;
                state_next = ST_KL;
            end
            ST_KL: begin
                if (status.gauss_far) begin
                    cmd.op     = OP_SH_ZERO;
                    state_next = ST_W;
                end else begin
                    cmd.op     = OP_KL;
                    state_next = ST_K;
                end
            end
            ST_K: begin
                cmd.op     = OP_K;
                state_next = ST_POS;
            end
            ST_POS: begin
                if (status.k_far) begin
                    cmd.op     = OP_SH_ZERO;
                    state_next = ST_W;
                end else begin
                    cmd.op     = OP_POS;
                    state_next = ST_TAB;
                end
            end
            ST_TAB: begin
                cmd.op     = OP_TAB;
                state_next = ST_STEP;
            end
            ST_STEP: begin
                cmd.op     = OP_STEP;
                state_next = ST_INTERP;
            end
            ST_INTERP: begin
                cmd.op     = OP_INTERP;
                state_next = ST_W;
            end
            ST_W: begin
                cmd.op     = OP_W;
                state_next = ST_WV;
            end
            ST_WV: begin
                cmd.op     = OP_WV;
                state_next = ST_C1;
            end
            ST_C1: begin
                cmd.op     = OP_C1;
                state_next = ST_C2;
            end
            ST_C2: begin
                cmd.op     = OP_C2;
                state_next = ST_CSUM;
            end
            ST_CSUM: begin
                cmd.op     = OP_CSUM;
                state_next = ST_ACC;
            end
            ST_ACC: begin
                // hold a last item while the previous result is still unread
                if (!(status.last && status.out_busy)) begin
                    cmd.op     = OP_ACC;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    `FWA_ASSERT_NEXT(a_acc_stall, aclk, aresetn, state_reg == ST_ACC && status.last && status.out_busy, state_reg == ST_ACC, "accumulate left while result pending")
    `FWA_ASSERT(a_no_overwrite, aclk, aresetn, cmd.op == OP_ACC |-> !(status.last && status.out_busy), "result overwritten")
    `FWA_ASSERT_NEXT(a_axis_done, aclk, aresetn, state_reg == ST_SHP && axis_reg == last_axis, state_reg == ST_W, "kernel axis loop overran")

endmodule

// ===== hdl/fwa_dp.sv =====
// Datapath: offsets, kernel evaluation on a shared multiplier, saturating sums.
`include "assert_macros.svh"
module fwa_dp
    import fwa_pkg::*;
#(
    parameter int EXP_TABLE_ENTRIES = EXP_TABLE_ENTRIES_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  cfg_t               cfg,
    input  cmd_t               cmd,
    output status_t            status,
    input  logic signed [31:0] s_cell_x,
    input  logic signed [31:0] s_cell_y,
    input  logic signed [31:0] s_cell_z,
    input  logic signed [31:0] s_query_x,
    input  logic signed [31:0] s_query_y,
    input  logic signed [31:0] s_query_z,
    input  logic [31:0]        s_cell_volume,
    input  logic signed [31:0] s_field_value,
    input  logic               s_last_item,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [63:0] m_weighted_sum,
    output logic signed [63:0] m_weight_volume_sum,
    output logic               m_saturated
);

    localparam int IDX_W = $clog2(EXP_TABLE_ENTRIES + 1);
    localparam int POS_W = 28 + IDX_W;

    logic [EXP_W-1:0] exp_rom [0:EXP_TABLE_ENTRIES];

    for (genvar i = 0; i <= EXP_TABLE_ENTRIES; i++) begin : g_exp
        localparam logic [63:0] Y = ((64'(i) * 64'd16) << 32) / EXP_TABLE_ENTRIES;
        assign exp_rom[i] = exp_table_value(Y);
    end

    logic [31:0]        ax_reg, ay_reg, az_reg;
    logic [31:0]        vol_reg;
    logic signed [31:0] val_reg;
    logic               last_reg;
    logic [EXP_W-1:0]   t_reg, q_reg, s_reg, shape_reg;
    logic [43:0]        sq_reg;
    logic [45:0]        r2_reg;
    logic [53:0]        kh_reg;
    logic [55:0]        kl_reg;
    logic [36:0]        k_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [27:0]        frac_reg;
    logic [EXP_W-1:0]   t0_reg, t1_reg, stp_reg;
    logic               t0_ge_reg;
    logic [31:0]        w_reg;
    logic [39:0]        wv_reg;
    logic signed [63:0] p1_reg, p2_reg, c_reg;
    logic signed [63:0] acc_v_reg, acc_w_reg;
    logic               sat_seen_reg;
    logic               m_valid_reg;
    logic signed [63:0] m_ws_reg, m_wvs_reg;
    logic               m_sat_reg;

    logic [31:0]        a_cur;
    logic [33:0]        a3;
    logic [33:0]        wide_w;
    logic signed [33:0] mul_a, mul_b;
    logic signed [67:0] prod;
    logic [EXP_W-1:0]   om_val;
    logic [EXP_W-1:0]   tab_diff;
    logic [IDX_W-1:0]   idx_inc;
    logic [56:0]        k_sum;
    logic [64:0]        acc_v_sum, acc_w_sum;
    logic [31:0]        az_in;

    function automatic logic [31:0] abs_diff(input logic signed [31:0] c,
                                             input logic signed [31:0] q);
        logic signed [32:0] d;
        d = {c[31], c} - {q[31], q};
        return d[32] ? 32'(-d) : d[31:0];
    endfunction

    // {overflow, clamped sum}
    function automatic logic [64:0] sat_add(input logic signed [63:0] a,
                                            input logic signed [63:0] b);
        logic [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63])
            return {1'b1, s[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF};
        return {1'b0, s[63:0]};
    endfunction

    always_comb begin
        case (cmd.axis)
            2'd0:    a_cur = ax_reg;
            2'd1:    a_cur = ay_reg;
            default: a_cur = az_reg;
        endcase
    end

    assign a3     = {a_cur, 1'b0} + {2'b00, a_cur};
    assign wide_w = {2'b00, cfg.filter_width};

    assign status.inside_le = (ax_reg <= cfg.filter_width) && (ay_reg <= cfg.filter_width)
                           && (az_reg <= cfg.filter_width);
    assign status.inside_lt = (ax_reg < cfg.filter_width) && (ay_reg < cfg.filter_width)
                           && (az_reg < cfg.filter_width);
    assign status.small3    = (a3 < wide_w);
    assign status.gauss_far = (kh_reg[53:24] != 30'd0);
    assign status.k_far     = (k_reg[36:28] != 9'd0);
    assign status.last      = last_reg;
    assign status.out_busy  = m_valid_reg && !m_ready;

    // shared multiplier operand select
    always_comb begin
        mul_a = 34'sd0;
        mul_b = 34'sd0;
        case (cmd.op)
            OP_OM_A: begin
                mul_a = {2'b00, cfg.filter_width - a_cur};
                mul_b = {2'b00, cfg.inv_filter_width};
            end
            OP_OM_3A: begin
                mul_a = {2'b00, cfg.filter_width - a3[31:0]};
                mul_b = {2'b00, cfg.inv_filter_width};
            end
            OP_SQ_T:  begin mul_a = {9'd0, t_reg};     mul_b = {9'd0, t_reg}; end
            OP_SQ_S:  begin mul_a = {9'd0, s_reg};     mul_b = {9'd0, s_reg}; end
            OP_DIV3:  begin mul_a = {9'd0, s_reg};     mul_b = DIV3_RECIP; end
            OP_SH_MT: begin mul_a = {9'd0, shape_reg}; mul_b = {9'd0, t_reg}; end
            OP_SH_MQ: begin mul_a = {9'd0, shape_reg}; mul_b = {9'd0, q_reg}; end
            OP_SQ_A:  begin mul_a = {2'b00, a_cur};    mul_b = {2'b00, a_cur}; end
            OP_KH: begin
                mul_a = {12'd0, r2_reg[45:24]};
                mul_b = {2'b00, cfg.gauss_exp_scale};
            end
            OP_KL: begin
                mul_a = {10'd0, r2_reg[23:0]};
                mul_b = {2'b00, cfg.gauss_exp_scale};
            end
            OP_POS:  begin mul_a = {6'd0, k_reg[27:0]}; mul_b = 34'(EXP_TABLE_ENTRIES); end
            OP_STEP: begin mul_a = {9'd0, tab_diff};    mul_b = {6'd0, frac_reg}; end
            OP_W: begin
                mul_a = {9'd0, shape_reg};
                mul_b = {2'b00, cfg.norm_factor};
            end
            OP_WV: begin mul_a = {2'b00, w_reg};  mul_b = {2'b00, vol_reg}; end
            OP_C1: begin
                mul_a = {18'd0, wv_reg[39:24]};
                mul_b = {{2{val_reg[31]}}, val_reg};
            end
            OP_C2: begin
                mul_a = {10'd0, wv_reg[23:0]};
                mul_b = {{2{val_reg[31]}}, val_reg};
            end
            default: ;
        endcase
    end

    assign prod = mul_a * mul_b;

    // min(1.0, product >> 20)
    assign om_val = (prod[67:45] != 23'd0 || prod[44:20] > ONE_Q24) ? ONE_Q24 : prod[44:20];

    assign tab_diff  = t0_ge_reg ? (t0_reg - t1_reg) : (t1_reg - t0_reg);
    assign idx_inc   = idx_reg + IDX_W'(1);
    assign k_sum     = {9'd0, kh_reg[23:0], 24'd0} + {1'b0, kl_reg};
    assign acc_v_sum = sat_add(acc_v_reg, c_reg);
    assign acc_w_sum = sat_add(acc_w_reg, {24'd0, wv_reg});
    assign az_in     = cfg.three_dim ? abs_diff(s_cell_z, s_query_z) : 32'd0;

    // working registers, no reset needed
    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_LOAD: begin
                ax_reg   <= abs_diff(s_cell_x, s_query_x);
                ay_reg   <= abs_diff(s_cell_y, s_query_y);
                az_reg   <= az_in;
                vol_reg  <= s_cell_volume;
                val_reg  <= s_field_value;
                last_reg <= s_last_item;
                r2_reg   <= 46'd0;
            end
            OP_OM_A:    t_reg     <= om_val;
            OP_SQ_T:    q_reg     <= prod[48:24];
            OP_OM_3A:   s_reg     <= om_val;
            OP_SQ_S:    s_reg     <= prod[48:24];
            OP_DIV3:    s_reg     <= prod[57:33];
            OP_QSUB:    q_reg     <= (q_reg > s_reg) ? (q_reg - s_reg) : '0;
            OP_SH_ONE:  shape_reg <= ONE_Q24;
            OP_SH_ZERO: shape_reg <= '0;
            OP_SH_T:    shape_reg <= t_reg;
            OP_SH_Q:    shape_reg <= q_reg;
            OP_SH_MT:   shape_reg <= prod[48:24];
            OP_SH_MQ:   shape_reg <= prod[48:24];
            OP_SQ_A:    sq_reg    <= prod[63:20];
            OP_R2_ADD:  r2_reg    <= r2_reg + {2'b00, sq_reg};
            OP_KH:      kh_reg    <= prod[53:0];
            OP_KL:      kl_reg    <= prod[55:0];
            OP_K:       k_reg     <= k_sum[56:20];
            OP_POS: begin
                idx_reg  <= prod[POS_W-1:28];
                frac_reg <= prod[27:0];
            end
            OP_TAB: begin
                t0_reg    <= exp_rom[idx_reg];
                t1_reg    <= exp_rom[idx_inc];
                t0_ge_reg <= (exp_rom[idx_reg] >= exp_rom[idx_inc]);
            end
            OP_STEP:    stp_reg   <= prod[52:28];
            OP_INTERP:  shape_reg <= t0_ge_reg ? (t0_reg - stp_reg) : (t0_reg + stp_reg);
            OP_W:       w_reg     <= prod[55:24];
            OP_WV:      wv_reg    <= prod[63:24];
            OP_C1:      p1_reg    <= prod[63:0];
            OP_C2:      p2_reg    <= 64'(prod >>> 24);
            OP_CSUM:    c_reg     <= p1_reg + p2_reg;
            default: ;
        endcase
    end

    // sums and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_v_reg    <= '0;
            acc_w_reg    <= '0;
            sat_seen_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cmd.op == OP_ACC && last_reg) begin
                m_ws_reg     <= acc_v_sum[63:0];
                m_wvs_reg    <= acc_w_sum[63:0];
                m_sat_reg    <= sat_seen_reg | acc_v_sum[64] | acc_w_sum[64];
                m_valid_reg  <= 1'b1;
                acc_v_reg    <= '0;
                acc_w_reg    <= '0;
                sat_seen_reg <= 1'b0;
            end else begin
                if (m_valid_reg && m_ready)
                    m_valid_reg <= 1'b0;
                if (cmd.op == OP_ACC) begin
                    acc_v_reg    <= acc_v_sum[63:0];
                    acc_w_reg    <= acc_w_sum[63:0];
                    sat_seen_reg <= sat_seen_reg | acc_v_sum[64] | acc_w_sum[64];
                end
            end
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_weighted_sum      = m_ws_reg;
    assign m_weight_volume_sum = m_wvs_reg;
    assign m_saturated         = m_sat_reg;

    `FWA_ASSERT_NEXT(a_sum_clear, aclk, aresetn, cmd.op == OP_ACC && last_reg, acc_v_reg == 64'sd0 && acc_w_reg == 64'sd0 && !sat_seen_reg, "sums not cleared after last item")
    `FWA_ASSERT(a_result_src, aclk, aresetn, $rose(m_valid_reg) |-> $past(cmd.op == OP_ACC && last_reg), "result without last item")
    `FWA_ASSERT_NEXT(a_interp_range, aclk, aresetn, cmd.op == OP_INTERP, shape_reg <= ONE_Q24, "interpolated shape above one")

endmodule

// ===== tb/sv/tb_filter_kernel_weighted_accumulate.sv =====
// Self-checking testbench for the kernel-weighted neighbor accumulator.
`timescale 1ns / 1ps

module tb_filter_kernel_weighted_accumulate;
    import fwa_pkg::*;

    localparam logic [63:0] Q24_ONE  = 64'd16777216;
    localparam logic [63:0] LOW24    = 64'hFF_FFFF;
    localparam int          LUT_SIZE = 256;
    localparam int          SETTLE   = 60;
    localparam int          LIMIT    = 200000;
    localparam int          LONG_HOLD = 400;
    localparam int          EXT_ITEMS = 16;
    localparam int          PASS_ITEMS = 70;

    typedef struct {
        logic [31:0] cx, cy, cz, qx, qy, qz, vol, val;
        logic        last;
    } cell_item_t;

    typedef struct {
        logic [1:0]  mode;
        logic        td;
        logic [31:0] w, inv, norm, scale;
    } kcfg_t;

    typedef struct {
        logic signed [63:0] ws, wvs;
        logic               sat;
    } sums_t;

    typedef struct {
        int         sel;
        cell_item_t it;
        bit         typed;
        sums_t      tv;
    } row_t;

    logic               aclk = 1'b0;
    logic               aresetn;
    logic               psel, penable, pwrite, pready;
    logic [ADDR_W-1:0]  paddr;
    logic [31:0]        pwdata, prdata;
    logic               s_valid, s_ready, s_last_item;
    logic signed [31:0] s_cell_x, s_cell_y, s_cell_z, s_query_x, s_query_y, s_query_z;
    logic [31:0]        s_cell_volume;
    logic signed [31:0] s_field_value;
    logic               m_valid, m_ready;
    logic signed [63:0] m_weighted_sum, m_weight_volume_sum;
    logic               m_saturated;

    filter_kernel_weighted_accumulate dut (.*);

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // predictor state
    logic [31:0]        exp_lut [0:LUT_SIZE];
    kcfg_t              cfg;
    logic signed [63:0] acc_value, acc_weight;
    logic               acc_sat;
    sums_t              sums_q [$];

    int  err_cnt = 0;
    int  cycles = 0;
    int  results_seen = 0;
    int  items_sent = 0;
    bit  tx_idle = 1'b1;
    bit  rx_idle = 1'b1;
    bit  hold_req = 1'b0;
    int  rx_wait = 0;

    function automatic logic [63:0] exp_series(input logic [63:0] f);
        longint      s;
        logic [63:0] term;
        s = 64'sh1_0000_0000;
        term = 64'h1_0000_0000;
        for (int k = 1; k <= 24; k++) begin
            term = ((term * f) >> 32) / 64'(k);
            if (k & 1) s = s - longint'(term);
            else s = s + longint'(term);
        end
        return s > 0 ? 64'(s) : 64'd0;
    endfunction

    task automatic build_lut();
        logic [63:0] e1, y, r;
        e1 = exp_series(64'h8000_0000);
        e1 = (e1 * e1) >> 32;
        for (int i = 0; i <= LUT_SIZE; i++) begin
            y = ((64'(i) * 64'd16) << 32) / 64'(LUT_SIZE);
            r = exp_series(y & 64'hFFFF_FFFF);
            for (int j = 0; j < int'(y >> 32); j++) r = (r * e1) >> 32;
            exp_lut[i] = 32'((r + 64'd128) >> 8);
        end
    endtask

    function automatic logic [63:0] ramp(input logic [63:0] num);
        logic [63:0] t;
        t = (num * {32'd0, cfg.inv}) >> 20;
        return t > Q24_ONE ? Q24_ONE : t;
    endfunction

    function automatic logic [63:0] quad_term(input logic [63:0] a);
        logic [63:0] t, q, s, q2, wd;
        wd = {32'd0, cfg.w};
        t = ramp(wd - a);
        q = (t * t) >> 24;
        if (64'd3 * a < wd) begin
            s = ramp(wd - 64'd3 * a);
            q2 = ((s * s) >> 24) / 64'd3;
            q = q > q2 ? q - q2 : 64'd0;
        end
        return q;
    endfunction

    function automatic logic [63:0] gauss_term(input logic [63:0] ax, ay, az);
        logic [63:0] r2, rh, rl, k, pos, idx, frac, t0, t1, sc;
        sc = {32'd0, cfg.scale};
        r2 = ((ax * ax) >> 20) + ((ay * ay) >> 20) + ((az * az) >> 20);
        rh = r2 >> 24;
        rl = r2 & LOW24;
        if (rh * sc >= Q24_ONE) return 64'd0;
        k = (((rh * sc) << 24) + rl * sc) >> 20;
        if (k >= 64'd268435456) return 64'd0;    // far tail
        pos = k * 64'(LUT_SIZE);
        idx = pos >> 28;
        frac = pos & 64'hFFF_FFFF;
        t0 = {32'd0, exp_lut[idx]};
        t1 = {32'd0, exp_lut[idx + 1]};
        if (t0 >= t1) return t0 - (((t0 - t1) * frac) >> 28);
        return t0 + (((t1 - t0) * frac) >> 28);
    endfunction

    function automatic logic signed [63:0] sat_add(input logic signed [63:0] a, b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) begin
            acc_sat = 1'b1;
            return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end
        return s[63:0];
    endfunction

    task automatic accumulate_cell(input cell_item_t it, output bit emit, output sums_t r);
        longint      dx, dy, dz, val, contrib;
        logic [63:0] ax, ay, az, shape, w, wv, wd;
        wd = {32'd0, cfg.w};
        dx = longint'($signed(it.cx)) - longint'($signed(it.qx));
        dy = longint'($signed(it.cy)) - longint'($signed(it.qy));
        dz = cfg.td ? longint'($signed(it.cz)) - longint'($signed(it.qz)) : 0;
        ax = dx < 0 ? 64'(-dx) : 64'(dx);
        ay = dy < 0 ? 64'(-dy) : 64'(dy);
        az = dz < 0 ? 64'(-dz) : 64'(dz);
        shape = 64'd0;
        case (cfg.mode)
            MODE_BOX: if (ax <= wd && ay <= wd && az <= wd) shape = Q24_ONE;
            MODE_HAT: begin
                if (ax <= wd && ay <= wd && az <= wd) begin
                    shape = (ramp(wd - ax) * ramp(wd - ay)) >> 24;
                    if (cfg.td) shape = (shape * ramp(wd - az)) >> 24;
                end
            end
            MODE_GAUSS: shape = gauss_term(ax, ay, az);
            default: begin
                if (ax < wd && ay < wd && az < wd) begin
                    shape = (quad_term(ax) * quad_term(ay)) >> 24;
                    if (cfg.td) shape = (shape * quad_term(az)) >> 24;
                end
            end
        endcase
        w = (shape * {32'd0, cfg.norm}) >> 24;
        wv = (w * {32'd0, it.vol}) >> 24;
        val = longint'($signed(it.val));
        contrib = longint'(wv >> 24) * val + ((longint'(wv & LOW24) * val) >>> 24);
        acc_value = sat_add(acc_value, contrib);
        acc_weight = sat_add(acc_weight, longint'(wv));
        emit = it.last;
        r.ws = acc_value;
        r.wvs = acc_weight;
        r.sat = acc_sat;
        if (it.last) begin
            acc_value = 0;
            acc_weight = 0;
            acc_sat = 1'b0;
        end
    endtask

    // result side: random stalls, plus one long hold when requested
    always @(posedge aclk) begin
        int nw;
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_wait = 0;
        end else if (rx_wait > 0) begin
            rx_wait--;
            m_ready <= 1'b0;
        end else if (m_valid && m_ready) begin
            nw = hold_req ? LONG_HOLD : (rx_idle ? $urandom_range(0, 6) : 0);
            hold_req = 1'b0;
            rx_wait = nw;
            m_ready <= (nw == 0);
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        sums_t e;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (sums_q.size() == 0) begin
                err_cnt++;
                if (err_cnt <= 10) $display("unexpected result ws=%0d wvs=%0d",
                                            m_weighted_sum, m_weight_volume_sum);
            end else begin
                e = sums_q.pop_front();
                if (e.ws !== m_weighted_sum || e.wvs !== m_weight_volume_sum ||
                    e.sat !== m_saturated) begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("mismatch ws exp %0d got %0d, wvs exp %0d got %0d, sat exp %0b got %0b",
                                 e.ws, m_weighted_sum, e.wvs, m_weight_volume_sum,
                                 e.sat, m_saturated);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("tb_filter_kernel_weighted_accumulate: done, errors");
            $finish;
        end
    end

    // psel stays high across back-to-back writes; the caller closes the burst
    task automatic reg_write(input logic [2:0] idx, input logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
    endtask

    task automatic program_kernel(input kcfg_t c);
        reg_write(REG_FILTER_MODE, {30'd0, c.mode});
        reg_write(REG_THREE_DIM, {31'd0, c.td});
        reg_write(REG_FILTER_W, c.w);
        reg_write(REG_INV_W, c.inv);
        reg_write(REG_NORM, c.norm);
        reg_write(REG_GAUSS_SCALE, c.scale);
        psel <= 1'b0;
        penable <= 1'b0;
        cfg = c;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (sums_q.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic send_cell(input cell_item_t it, input bit typed, input sums_t tv);
        int    gap;
        bit    emit;
        sums_t r;
        gap = tx_idle ? $urandom_range(0, 6) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_cell_x <= it.cx;
        s_cell_y <= it.cy;
        s_cell_z <= it.cz;
        s_query_x <= it.qx;
        s_query_y <= it.qy;
        s_query_z <= it.qz;
        s_cell_volume <= it.vol;
        s_field_value <= it.val;
        s_last_item <= it.last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
        accumulate_cell(it, emit, r);
        if (emit) sums_q.push_back(typed ? tv : r);
    endtask

    function automatic cell_item_t mk(input logic [31:0] cx, cy, cz, qx, qy, qz, vol, val,
                                      input bit last);
        cell_item_t it;
        it.cx = cx; it.cy = cy; it.cz = cz;
        it.qx = qx; it.qy = qy; it.qz = qz;
        it.vol = vol; it.val = val; it.last = last;
        return it;
    endfunction

    function automatic sums_t sv3(input logic signed [63:0] a, b, input logic s);
        sums_t r;
        r.ws = a; r.wvs = b; r.sat = s;
        return r;
    endfunction

    function automatic kcfg_t kc(input logic [1:0] m, input logic t,
                                 input logic [31:0] w, inv, norm, scale);
        kcfg_t c;
        c.mode = m; c.td = t; c.w = w; c.inv = inv; c.norm = norm; c.scale = scale;
        return c;
    endfunction

    function automatic cell_item_t rand_cell(input bit last);
        cell_item_t  it;
        logic [31:0] span;
        span = (cfg.w > 32'h0040_0000 || cfg.w == 0) ? 32'h0040_0000 : cfg.w;
        it.qx = $urandom; it.qy = $urandom; it.qz = $urandom;
        if ($urandom_range(0, 7) == 0) begin
            it.cx = $urandom; it.cy = $urandom; it.cz = $urandom;
        end else begin
            // mostly near the query so the kernel is nonzero
            it.cx = it.qx + $urandom_range(0, 4 * span) - 2 * span;
            it.cy = it.qy + $urandom_range(0, 4 * span) - 2 * span;
            it.cz = it.qz + $urandom_range(0, 4 * span) - 2 * span;
        end
        case ($urandom_range(0, 9))
            0: it.vol = 32'd0;
            1: it.vol = $urandom;
            default: it.vol = $urandom_range(0, 32'h0400_0000);
        endcase
        it.val = $urandom;
        it.last = last;
        return it;
    endfunction

    kcfg_t      kset [0:7];
    row_t       rows [$];
    cell_item_t it;
    kcfg_t      rc;
    sums_t      none;
    int         cur;
    logic [31:0] one, neg_one, half;

    task automatic add_row(input int sel, input cell_item_t ci, input bit typed,
                           input sums_t tv);
        row_t r;
        r.sel = sel; r.it = ci; r.typed = typed; r.tv = tv;
        rows.push_back(r);
    endtask

    initial begin
        aresetn = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        s_valid = 1'b0; s_last_item = 1'b0;
        s_cell_x = '0; s_cell_y = '0; s_cell_z = '0;
        s_query_x = '0; s_query_y = '0; s_query_z = '0;
        s_cell_volume = '0; s_field_value = '0;
        build_lut();
        acc_value = 0; acc_weight = 0; acc_sat = 1'b0;
        one = 32'h0100_0000; neg_one = 32'hFF00_0000; half = 32'h0008_0000;
        none = sv3(0, 0, 1'b0);

        kset[0] = kc(MODE_BOX, 1'b1, 32'h0010_0000, 32'h0100_0000, 32'h0100_0000, 32'h0080_0000);
        kset[1] = kc(MODE_HAT, 1'b1, 32'h0010_0000, 32'h0100_0000, 32'h0100_0000, 32'h0080_0000);
        kset[2] = kc(MODE_GAUSS, 1'b1, 32'h0010_0000, 32'h0100_0000, 32'd1065220, 32'h0080_0000);
        kset[3] = kc(MODE_QUAD, 1'b0, 32'h0010_0000, 32'h0100_0000, 32'd47775744, 32'h0080_0000);
        kset[4] = kc(MODE_QUAD, 1'b1, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        kset[5] = kc(MODE_BOX, 1'b0, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 32'd0);
        kset[6] = kc(MODE_GAUSS, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
        kset[7] = kc(MODE_HAT, 1'b0, 32'd0, 32'h0100_0000, 32'h0100_0000, 32'h0080_0000);
        cfg = kset[0];

        // reset-value box kernel
        add_row(0, mk(0, 0, 0, 0, 0, 0, one, one, 1), 1, sv3(64'sd16777216, 64'sd16777216, 0));
        add_row(0, mk(0, 0, 0, 0, 0, 0, 0, 32'h7FFF_FFFF, 1), 1, none);
        add_row(0, mk(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                      32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1), 1, none);
        add_row(0, mk(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                      32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 1), 1, none);
        // offset exactly at the half width is still inside
        add_row(0, mk(32'h0010_0000, 0, 0, 0, 0, 0, one, neg_one, 1), 1,
                sv3(-64'sd16777216, 64'sd16777216, 0));
        add_row(0, mk(32'h0005_0000, 32'hFFFF_0000, 32'h000F_FFFF, 0, 0, 0, one, 32'h0300_0000, 0), 0, none);
        add_row(0, mk(32'h0020_0000, 0, 0, 0, 0, 0, one, one, 0), 0, none);
        add_row(0, mk(5, 6, 7, 1, 2, 3, 32'h0080_0000, neg_one, 1), 0, none);
        add_row(1, mk(half, 0, 0, 0, 0, 0, one, one, 0), 0, none);
        add_row(1, mk(32'h0003_0000, 32'hFFFA_0000, 32'h0001_0000, 0, 0, 0, 32'h0200_0000, neg_one, 1), 0, none);
        add_row(2, mk(0, 0, 0, 0, 0, 0, one, one, 0), 0, none);
        add_row(2, mk(32'h0010_0000, 0, 0, 0, 0, 0, one, one, 0), 0, none);
        add_row(2, mk(32'h0030_0000, 32'h0001_2345, 0, 0, 0, 0, one, one, 0), 0, none);
        add_row(2, mk(32'h0060_0000, 0, 0, 0, 0, 0, one, one, 1), 0, none);
        add_row(3, mk(32'h0003_3333, 0, 32'h7FFF_FFFF, 0, 0, 32'h8000_0000, one, one, 0), 0, none);
        add_row(3, mk(half, half, 0, 0, 0, 0, one, 32'h0500_0000, 0), 0, none);
        add_row(3, mk(32'h000F_D70A, 32'h0000_1000, 0, 0, 0, 0, one, one, 1), 0, none);
        // zero half width: quadratic and hat give no weight
        add_row(4, mk(0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1), 1, none);
        add_row(6, mk(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                      32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 1), 0, none);
        add_row(7, mk(0, 0, 0, 0, 0, 0, one, one, 1), 1, none);

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        cur = -1;
        foreach (rows[i]) begin
            if (rows[i].sel != cur) begin
                drain();
                program_kernel(kset[rows[i].sel]);
                cur = rows[i].sel;
            end
            send_cell(rows[i].it, rows[i].typed, rows[i].tv);
        end
        drain();

        for (int p = 0; p < 6; p++) begin
            rc.mode = 2'(p % 4);
            rc.td = $urandom_range(0, 1);
            rc.w = $urandom_range(32'h0001_0000, 32'h0040_0000);
            rc.inv = ($urandom_range(0, 3) == 0) ? $urandom : 32'(64'h1000_0000_0000 / rc.w);
            rc.norm = ($urandom_range(0, 3) == 0) ? $urandom
                                                  : $urandom_range(32'h0010_0000, 32'h0400_0000);
            rc.scale = ($urandom_range(0, 3) == 0) ? $urandom
                                                   : $urandom_range(32'h0010_0000, 32'h0400_0000);
            program_kernel(rc);
            tx_idle = (p != 1) && (p != 3);
            rx_idle = (p != 2);
            if (p == 3) hold_req = 1'b1;   // receiver parks while the sender keeps going
            for (int n = 0; n < PASS_ITEMS; n++)
                send_cell(rand_cell(n == PASS_ITEMS - 1 || $urandom_range(0, 7) == 0), 0, none);
            drain();
        end

        // short query of the largest negative contributions, back to back
        rx_idle = 1'b1;
        tx_idle = 1'b0;
        program_kernel(kset[5]);
        for (int n = 0; n < EXT_ITEMS; n++) begin
            it = mk($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                    32'hFFFF_FFFF, 32'h8000_0000, n == EXT_ITEMS - 1);
            send_cell(it, 0, none);
        end
        drain();

        $display("covered all four kernels in 2-D and 3-D, register extremes, zero widths,");
        $display("far Gaussian tail and extreme contributions: %0d items, %0d results",
                 items_sent, results_seen);
        if (err_cnt == 0 && sums_q.size() == 0) begin
            $display("tb_filter_kernel_weighted_accumulate: done, clean");
        end else begin
            $display("tb_filter_kernel_weighted_accumulate: done, errors");
        end
        $finish;
    end

endmodule
